[hdl/jccm_pkg.sv]
// Shared types, constants and the divider step of the joystick mapper.
// No dependencies; used by joystick_center_calibrated_mapper_unit.
package jccm_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int SAMPLE_MAX  = 4095;
	localparam int POS_W       = 7;
	localparam int CAL_SAMPLES = 20;

	localparam int SUM_W   = $clog2(CAL_SAMPLES * SAMPLE_MAX + 1);
	localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
	// |(s - a) * 50| <= 4095 * 50
	localparam int NUM_W   = 18;
	localparam int DVD_MAX = (SUM_W > NUM_W) ? SUM_W : NUM_W;
	// two quotient bits per cycle, so the dividend is padded to even width
	localparam int DIV_W    = ((DVD_MAX + 1) / 2) * 2;
	localparam int DIV_ITER = DIV_W / 2;
	localparam int ITER_W   = $clog2(DIV_ITER);
	localparam int V_W      = DIV_W + 2;

	localparam logic [SAMPLE_W-1:0] CENTRE_RST = 12'd2048;
	localparam logic [SAMPLE_W-1:0] X_LOW_RST  = 12'd490;
	localparam logic [SAMPLE_W-1:0] X_HIGH_RST = 12'd3150;
	localparam logic [SAMPLE_W-1:0] Y_LOW_RST  = 12'd530;
	localparam logic [SAMPLE_W-1:0] Y_HIGH_RST = 12'd3590;
	localparam logic [POS_W-1:0]    POS_MID    = 7'd50;
	localparam logic [POS_W-1:0]    POS_MAX    = 7'd99;
	localparam logic [POS_W-1:0]    RISE_LOW   = 7'd50;
	localparam logic [POS_W-1:0]    RISE_HIGH  = 7'd49;

	typedef enum logic [1:0] {
		REG_X_LOW  = 2'd0,
		REG_X_HIGH = 2'd1,
		REG_Y_LOW  = 2'd2,
		REG_Y_HIGH = 2'd3
	} reg_idx_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_ACC  = 6'b000010,
		ST_CDIV = 6'b000100,
		ST_MSET = 6'b001000,
		ST_MDIV = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] rem;
		logic                qbit;
	} div_step_t;

	// one restoring step: shift in a dividend bit, subtract if it fits
	function automatic div_step_t div_step(input logic [SAMPLE_W-1:0] rem,
		input logic dvd_bit, input logic [SAMPLE_W-1:0] den);
		logic [SAMPLE_W:0] trial;
		div_step_t         r;
		trial = {rem, dvd_bit};
		if (trial >= {1'b0, den}) begin
			trial  = trial - {1'b0, den};
			r.qbit = 1'b1;
		end else begin
			r.qbit = 1'b0;
		end
		r.rem = trial[SAMPLE_W-1:0];
		return r;
	endfunction

endpackage

[hdl/joystick_center_calibrated_mapper_unit.sv]
// Top level of the joystick mapper: sequencer, shared divider, state.
// Depends on jccm_pkg (constants, state codes, divider step).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: operation, x_raw,
//   y_raw. operation = 1 also adds both samples to the centre calibration
//   sums; every CAL_SAMPLES such words the centres are recomputed as the
//   truncated mean, and that word is mapped with the new centres and
//   reports cal_done = 1.
//   Output channel (out_valid/out_ready) returns one word per input word:
//   x_pos, y_pos (0..99, 50 at centre) and cal_done.
//   Config port: cfg_wr_en writes cfg_data into limit register cfg_index
//   (x low, x high, y low, y high) in the same edge; write only when idle.
// Sequencing:
//   One radix-4 restoring divider (two quotient bits per cycle) does all
//   divisions, DIV_ITER = 9 iterations each. A plain word goes from
//   acceptance to out_valid through two map setups, two divisions and the
//   finish cycle; a calibration word adds an accumulate step first, and a
//   word that completes calibration also runs two centre divisions.
//   Words are processed one at a time; in_ready returns the cycle after the
//   finish cycle, so a word is taken only after the previous result is registered.
//   The result sits in an output register, so the next word is accepted
//   while the previous result still waits; if it still waits when the next
//   result is ready, the finish cycle holds until the output register frees up.
// Reset:
//   arst_n clears the sequencer, sums and count, sets both centres to 2048
//   and the limits to 490/3150 (x) and 530/3590 (y).
module joystick_center_calibrated_mapper_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [jccm_pkg::SAMPLE_W-1:0] x_raw,
	input  logic [jccm_pkg::SAMPLE_W-1:0] y_raw,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [jccm_pkg::POS_W-1:0]    x_pos,
	output logic [jccm_pkg::POS_W-1:0]    y_pos,
	output logic                          cal_done,
	input  logic                          cfg_wr_en,
	input  logic [1:0]                    cfg_index,
	input  logic [jccm_pkg::SAMPLE_W-1:0] cfg_data
);

	localparam int SW = jccm_pkg::SAMPLE_W;
	localparam int DW = jccm_pkg::DIV_W;

	jccm_pkg::state_t state_q;

	// limit registers
	logic [SW-1:0] x_low_q, x_high_q, y_low_q, y_high_q;

	// calibration state
	logic [SW-1:0]                  x_centre_q, y_centre_q;
	logic [jccm_pkg::SUM_W-1:0]     x_sum_q, y_sum_q;
	logic [jccm_pkg::CNT_W-1:0]     cnt_q;

	// current word
	logic [SW-1:0] xs_q, ys_q;
	logic          axis_q;   // 0 = x, 1 = y
	logic          done_q;

	// divider
	logic [DW-1:0]               dq_q;   // dividend out at top, quotient in at bottom
	logic [SW-1:0]               rem_q;
	logic [SW-1:0]               den_q;
	logic [jccm_pkg::ITER_W-1:0] iter_q;
	logic                        neg_q;  // map quotient sign
	logic                        zero_q; // zero span
	logic                        above_q;

	logic [jccm_pkg::POS_W-1:0] x_res_q, y_res_q;

	// output register
	logic                       out_valid_q;
	logic [jccm_pkg::POS_W-1:0] x_pos_q, y_pos_q;
	logic                       cal_done_q;

	// ---------------- divider datapath: two steps per cycle ----------------
	jccm_pkg::div_step_t st1, st2;
	logic [DW-1:0]       dq_nxt;
	logic                div_last;

	always_comb begin
		st1      = jccm_pkg::div_step(rem_q, dq_q[DW-1], den_q);
		st2      = jccm_pkg::div_step(st1.rem, dq_q[DW-2], den_q);
		dq_nxt   = {dq_q[DW-3:0], st1.qbit, st2.qbit};
		div_last = (iter_q == jccm_pkg::ITER_W'(jccm_pkg::DIV_ITER - 1));
	end

	// ---------------- map setup: segment choice, numerator, span -----------
	logic [SW-1:0]                s_sel, lo_sel, hi_sel, c_sel, a_sel, b_sel;
	logic [jccm_pkg::POS_W-1:0]   rise;
	logic signed [SW:0]           diff, span;
	logic signed [SW+jccm_pkg::POS_W+1:0] prod;
	logic [SW+jccm_pkg::POS_W+1:0] prod_mag;
	logic [SW:0]                  span_mag;
	logic                         above;

	always_comb begin
		s_sel  = axis_q ? ys_q       : xs_q;
		lo_sel = axis_q ? y_low_q    : x_low_q;
		hi_sel = axis_q ? y_high_q   : x_high_q;
		c_sel  = axis_q ? y_centre_q : x_centre_q;
		above  = (s_sel > c_sel);
		a_sel  = above ? c_sel  : lo_sel;
		b_sel  = above ? hi_sel : c_sel;
		rise   = above ? jccm_pkg::RISE_HIGH : jccm_pkg::RISE_LOW;
		diff   = $signed({1'b0, s_sel}) - $signed({1'b0, a_sel});
		span   = $signed({1'b0, b_sel}) - $signed({1'b0, a_sel});
		prod   = diff * $signed({1'b0, rise});
		prod_mag = prod[SW+jccm_pkg::POS_W+1] ? 
			(SW+jccm_pkg::POS_W+2)'(-prod) : prod;
		span_mag = span[SW] ? (SW+1)'(-span) : span;
	end

	// ---------------- map finish: sign, offset, clamp ----------------------
	logic signed [jccm_pkg::V_W-1:0] q_s, v;
	logic [jccm_pkg::POS_W-1:0]      pos_new;

	always_comb begin
		q_s = $signed({2'b00, dq_nxt});
		if (neg_q) begin
			q_s = -q_s;
		end
		v = q_s + $signed(jccm_pkg::V_W'(above_q ? jccm_pkg::POS_MID : 7'd0));
		if (zero_q || v[jccm_pkg::V_W-1]) begin
			pos_new = '0;   // zero span or a negative value, clamped to 0
		end else if (v > $signed(jccm_pkg::V_W'(jccm_pkg::POS_MAX))) begin
			pos_new = jccm_pkg::POS_MAX;
		end else begin
			pos_new = v[jccm_pkg::POS_W-1:0];
		end
	end

	// ---------------- calibration accumulate -------------------------------
	logic [jccm_pkg::SUM_W-1:0] x_sum_add, y_sum_add;
	logic [jccm_pkg::CNT_W-1:0] cnt_add;
	logic                       cal_full;

	always_comb begin
		x_sum_add = x_sum_q + jccm_pkg::SUM_W'(xs_q);
		y_sum_add = y_sum_q + jccm_pkg::SUM_W'(ys_q);
		cnt_add   = cnt_q + 1'b1;
		cal_full  = (cnt_add == jccm_pkg::CNT_W'(jccm_pkg::CAL_SAMPLES));
	end

	logic out_free;
	logic fin_go;
	assign out_free = !out_valid_q || out_ready;
	assign fin_go   = (state_q == jccm_pkg::ST_FIN) && out_free;

	// ---------------- config registers -------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= jccm_pkg::X_LOW_RST;
			x_high_q <= jccm_pkg::X_HIGH_RST;
			y_low_q  <= jccm_pkg::Y_LOW_RST;
			y_high_q <= jccm_pkg::Y_HIGH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				jccm_pkg::REG_X_LOW:  x_low_q  <= cfg_data;
				jccm_pkg::REG_X_HIGH: x_high_q <= cfg_data;
				jccm_pkg::REG_Y_LOW:  y_low_q  <= cfg_data;
				jccm_pkg::REG_Y_HIGH: y_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- output register --------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			x_pos_q     <= '0;
			y_pos_q     <= '0;
			cal_done_q  <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
			x_pos_q     <= x_res_q;
			y_pos_q     <= y_res_q;
			cal_done_q  <= done_q;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// ---------------- sequencer and state ----------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jccm_pkg::ST_IDLE;
			x_centre_q  <= jccm_pkg::CENTRE_RST;
			y_centre_q  <= jccm_pkg::CENTRE_RST;
			x_sum_q     <= '0;
			y_sum_q     <= '0;
			cnt_q       <= '0;
			xs_q        <= '0;
			ys_q        <= '0;
			axis_q      <= 1'b0;
			done_q      <= 1'b0;
			dq_q        <= '0;
			rem_q       <= '0;
			den_q       <= '0;
			iter_q      <= '0;
			neg_q       <= 1'b0;
			zero_q      <= 1'b0;
			above_q     <= 1'b0;
			x_res_q     <= '0;
			y_res_q     <= '0;
		end else begin
			case (state_q)
				jccm_pkg::ST_IDLE: begin
					if (in_valid) begin
						xs_q    <= x_raw;
						ys_q    <= y_raw;
						axis_q  <= 1'b0;
						done_q  <= 1'b0;
						state_q <= operation ? jccm_pkg::ST_ACC : jccm_pkg::ST_MSET;
					end
				end
				jccm_pkg::ST_ACC: begin
					if (cal_full) begin
						// centre = sum / CAL_SAMPLES on the shared divider
						dq_q    <= DW'(x_sum_add);
						rem_q   <= '0;
						den_q   <= SW'(jccm_pkg::CAL_SAMPLES);
						iter_q  <= '0;
						state_q <= jccm_pkg::ST_CDIV;
					end else begin
						state_q <= jccm_pkg::ST_MSET;
					end
					x_sum_q <= x_sum_add;
					y_sum_q <= y_sum_add;
					cnt_q   <= cnt_add;
				end
				jccm_pkg::ST_CDIV: begin
					if (div_last) begin
						iter_q <= '0;
						if (!axis_q) begin
							x_centre_q <= dq_nxt[SW-1:0];
							axis_q     <= 1'b1;
							dq_q       <= DW'(y_sum_q);
							rem_q      <= '0;
						end else begin
							y_centre_q <= dq_nxt[SW-1:0];
							x_sum_q    <= '0;
							y_sum_q    <= '0;
							cnt_q      <= '0;
							done_q     <= 1'b1;
							axis_q     <= 1'b0;
							state_q    <= jccm_pkg::ST_MSET;
						end
					end else begin
						dq_q   <= dq_nxt;
						rem_q  <= st2.rem;
						iter_q <= iter_q + 1'b1;
					end
				end
				jccm_pkg::ST_MSET: begin
					dq_q    <= DW'(prod_mag[jccm_pkg::NUM_W-1:0]);
					rem_q   <= '0;
					den_q   <= span_mag[SW-1:0];
					neg_q   <= prod[SW+jccm_pkg::POS_W+1] ^ span[SW];
					zero_q  <= (span == '0);
					above_q <= above;
					iter_q  <= '0;
					state_q <= jccm_pkg::ST_MDIV;
				end
				jccm_pkg::ST_MDIV: begin
					if (div_last) begin
						iter_q <= '0;
						if (!axis_q) begin
							x_res_q <= pos_new;
							axis_q  <= 1'b1;
							state_q <= jccm_pkg::ST_MSET;
						end else begin
							y_res_q <= pos_new;
							state_q <= jccm_pkg::ST_FIN;
						end
					end else begin
						dq_q   <= dq_nxt;
						rem_q  <= st2.rem;
						iter_q <= iter_q + 1'b1;
					end
				end
				jccm_pkg::ST_FIN: begin
					if (out_free) begin
						state_q <= jccm_pkg::ST_IDLE;
					end
				end
				default: state_q <= jccm_pkg::ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == jccm_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign x_pos     = x_pos_q;
	assign y_pos     = y_pos_q;
	assign cal_done  = cal_done_q;

	// ---------------- assertions --------------------------------------------
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (x_pos <= jccm_pkg::POS_MAX && y_pos <= jccm_pkg::POS_MAX))
		else $error("mapped position above 99");

	a_cnt_below: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jccm_pkg::ST_IDLE |->
			cnt_q < jccm_pkg::CNT_W'(jccm_pkg::CAL_SAMPLES))
		else $error("calibration count not wrapped at set size");

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_map_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !operation) |=> ##1 $stable(cnt_q))
		else $error("map-only word touched calibration count");

endmodule

[dv/jccm_checker.sv]
// Checker for the joystick mapper: watches the word and config channels,
// predicts every result word and compares it with what the block returns.
// Depends on jccm_pkg for widths, reset values and register indexes.
module jccm_checker
	import jccm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                operation,
	input  logic [SAMPLE_W-1:0] x_raw,
	input  logic [SAMPLE_W-1:0] y_raw,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [POS_W-1:0]    x_pos,
	input  logic [POS_W-1:0]    y_pos,
	input  logic                cal_done,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_index,
	input  logic [SAMPLE_W-1:0] cfg_data,
	output int                  errors,
	output int                  pending,
	output int                  words_checked,
	output int                  sets_done
);

	typedef struct packed {
		logic [POS_W-1:0] x_pos;
		logic [POS_W-1:0] y_pos;
		logic             cal_done;
	} pos_word_t;

	logic [SAMPLE_W-1:0] x_lo, x_hi, y_lo, y_hi;
	logic [SAMPLE_W-1:0] x_ctr, y_ctr;
	logic [SUM_W-1:0]    x_sum, y_sum;
	logic [CNT_W-1:0]    n_cal;
	pos_word_t           pos_q[$];
	int                  n_err, n_words, n_sets;

	// segment map: (s - a) * rise / (b - a) + base, zero span gives -1, then clamp
	function automatic logic [POS_W-1:0] axis_position(int s, int lo, int ctr, int hi);
		int a, b, base, rise, v;
		if (s <= ctr) begin
			a    = lo;
			b    = ctr;
			base = 0;
			rise = int'(RISE_LOW);
		end else begin
			a    = ctr;
			b    = hi;
			base = int'(POS_MID);
			rise = int'(RISE_HIGH);
		end
		if (b == a)
			v = -1;
		else
			v = ((s - a) * rise) / (b - a) + base;
		if (v < 0)
			v = 0;
		if (v > int'(POS_MAX))
			v = int'(POS_MAX);
		return v[POS_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pos_word_t got, want;
		if (!arst_n) begin
			x_lo    = X_LOW_RST;
			x_hi    = X_HIGH_RST;
			y_lo    = Y_LOW_RST;
			y_hi    = Y_HIGH_RST;
			x_ctr   = CENTRE_RST;
			y_ctr   = CENTRE_RST;
			x_sum   = '0;
			y_sum   = '0;
			n_cal   = '0;
			n_err   = 0;
			n_words = 0;
			n_sets  = 0;
			pos_q.delete();
			errors        <= 0;
			pending       <= 0;
			words_checked <= 0;
			sets_done     <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_X_LOW:  x_lo = cfg_data;
					REG_X_HIGH: x_hi = cfg_data;
					REG_Y_LOW:  y_lo = cfg_data;
					REG_Y_HIGH: y_hi = cfg_data;
					default: ;
				endcase
			end

			// a result can never belong to a word accepted at the same edge,
			// so the compare runs before this edge's prediction is queued
			if (out_valid && out_ready) begin
				got = '{x_pos, y_pos, cal_done};
				if (pos_q.size() == 0) begin
					if (n_err < 10)
						$display("[%0t] unexpected word: x_pos=%0d y_pos=%0d cal_done=%0b",
							$realtime, got.x_pos, got.y_pos, got.cal_done);
					n_err++;
				end else begin
					want = pos_q.pop_front();
					n_words++;
					if (want.cal_done)
						n_sets++;
					if (got.x_pos !== want.x_pos || got.y_pos !== want.y_pos ||
						got.cal_done !== want.cal_done) begin
						if (n_err < 10)
							$display("[%0t] mismatch: x_pos %0d/%0d y_pos %0d/%0d cal_done %0b/%0b (exp/act)",
								$realtime, want.x_pos, got.x_pos, want.y_pos, got.y_pos,
								want.cal_done, got.cal_done);
						n_err++;
					end
				end
			end

			if (in_valid && in_ready) begin
				want.cal_done = 1'b0;
				if (operation) begin
					x_sum = x_sum + x_raw;
					y_sum = y_sum + y_raw;
					n_cal = n_cal + 1'b1;
					// completing word: centres move first, then this word is mapped
					if (n_cal >= CAL_SAMPLES) begin
						x_ctr = SAMPLE_W'(x_sum / CAL_SAMPLES);
						y_ctr = SAMPLE_W'(y_sum / CAL_SAMPLES);
						x_sum = '0;
						y_sum = '0;
						n_cal = '0;
						want.cal_done = 1'b1;
					end
				end
				want.x_pos = axis_position(int'(x_raw), int'(x_lo), int'(x_ctr), int'(x_hi));
				want.y_pos = axis_position(int'(y_raw), int'(y_lo), int'(y_ctr), int'(y_hi));
				pos_q.push_back(want);
			end

			errors        <= n_err;
			pending       <= pos_q.size();
			words_checked <= n_words;
			sets_done     <= n_sets;
		end
	end

endmodule

[dv/tb.sv]
// Testbench top for joystick_center_calibrated_mapper_unit: clock, reset,
// stimulus on the word and config channels, watchdog and verdict.
// Depends on jccm_pkg and on jccm_checker, which does all prediction.
module tb;
	import jccm_pkg::*;

	// cycles with no handshake on either channel before the run is abandoned;
	// well above the slowest word plus the largest sender gap and receiver stall
	localparam int STALL_LIMIT  = 2000;
	// words per random phase, and the number of phases
	localparam int PHASE_WORDS  = 75;
	localparam int N_PHASES     = 7;
	// settle time after the last result, longer than a completing word takes
	localparam int TAIL_CYCLES  = 60;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                operation;
	logic [SAMPLE_W-1:0] x_raw;
	logic [SAMPLE_W-1:0] y_raw;
	logic                out_valid;
	logic                out_ready;
	logic [POS_W-1:0]    x_pos;
	logic [POS_W-1:0]    y_pos;
	logic                cal_done;
	logic                cfg_wr_en;
	logic [1:0]          cfg_index;
	logic [SAMPLE_W-1:0] cfg_data;

	int errors, pending, words_checked, sets_done;

	// stimulus-side bookkeeping only (no prediction here)
	int lim [4];       // limits last written, used to aim samples at the segment ends
	int cal_sent;      // calibration words sent so far, to line up a fresh set
	int n_settings;    // limit settings applied
	bit gap_on;        // off gives back-to-back stretches on both sides
	int stall_cycles;

	joystick_center_calibrated_mapper_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.x_raw     (x_raw),
		.y_raw     (y_raw),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.cal_done  (cal_done),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	jccm_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.x_raw         (x_raw),
		.y_raw         (y_raw),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.x_pos         (x_pos),
		.y_pos         (y_pos),
		.cal_done      (cal_done),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending),
		.words_checked (words_checked),
		.sets_done     (sets_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// per-word wait drawn at random, or none during back-to-back stretches
	function automatic int pick_gap();
		return gap_on ? $urandom_range(0, 8) : 0;
	endfunction

	function automatic int clamp_sample(int v);
		if (v < 0)
			return 0;
		if (v > SAMPLE_MAX)
			return SAMPLE_MAX;
		return v;
	endfunction

	// calibration target: often pinned near a rail so centres reach the extremes
	function automatic int pick_target();
		case ($urandom_range(0, 3))
			0:       return $urandom_range(0, 40);
			1:       return $urandom_range(SAMPLE_MAX - 40, SAMPLE_MAX);
			default: return $urandom_range(0, SAMPLE_MAX);
		endcase
	endfunction

	// map samples: aimed at the centre, at either limit, at the rails, or anywhere
	function automatic logic [SAMPLE_W-1:0] pick_sample(int tgt, int lo, int hi);
		int v;
		case ($urandom_range(0, 5))
			1:       v = tgt + $urandom_range(0, 6) - 3;
			2:       v = lo + $urandom_range(0, 6) - 3;
			3:       v = hi + $urandom_range(0, 6) - 3;
			4:       v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
			default: v = $urandom_range(0, SAMPLE_MAX);
		endcase
		return SAMPLE_W'(clamp_sample(v));
	endfunction

	// one input word; valid stays up from the previous word when there is no gap
	task automatic send(logic op, logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		x_raw     <= xs;
		y_raw     <= ys;
		do @(posedge clk); while (!in_ready);
		if (op)
			cal_sent++;
	endtask

	// stop sending and wait until every predicted word has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// all four limits, on consecutive edges; enable drops once at the end
	task automatic set_limits(int xl, int xh, int yl, int yh);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_X_LOW;
		cfg_data  <= SAMPLE_W'(xl);
		@(posedge clk);
		cfg_index <= REG_X_HIGH;
		cfg_data  <= SAMPLE_W'(xh);
		@(posedge clk);
		cfg_index <= REG_Y_LOW;
		cfg_data  <= SAMPLE_W'(yl);
		@(posedge clk);
		cfg_index <= REG_Y_HIGH;
		cfg_data  <= SAMPLE_W'(yh);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		lim[REG_X_LOW]  = xl;
		lim[REG_X_HIGH] = xh;
		lim[REG_Y_LOW]  = yl;
		lim[REG_Y_HIGH] = yh;
		n_settings++;
	endtask

	// receiver: draws a stall per word, keeps ready up through quiet stretches
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// watchdog: only quiet stretches count, so the limit is per word, not per run
	initial stall_cycles = 0;
	always @(posedge clk) begin
		if (arst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
			stall_cycles <= stall_cycles + 1;
		else
			stall_cycles <= 0;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d words outstanding",
				stall_cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int p, k, n, xt, yt, xl, xh, yl, yh;
		logic                op;
		logic [SAMPLE_W-1:0] xs, ys;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		operation  = 1'b0;
		x_raw      = '0;
		y_raw      = '0;
		cfg_wr_en  = 1'b0;
		cfg_index  = REG_X_LOW;
		cfg_data   = '0;
		gap_on     = 1'b1;
		cal_sent   = 0;
		n_settings = 0;
		lim[REG_X_LOW]  = int'(X_LOW_RST);
		lim[REG_X_HIGH] = int'(X_HIGH_RST);
		lim[REG_Y_LOW]  = int'(Y_LOW_RST);
		lim[REG_Y_HIGH] = int'(Y_HIGH_RST);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset limits and centres ---
		// rails, exactly at the centre, one either side of it, at the limits
		send(1'b0, 12'd0, 12'd0);
		send(1'b0, 12'd4095, 12'd4095);
		send(1'b0, 12'd2048, 12'd2048);
		send(1'b0, 12'd2049, 12'd2047);
		send(1'b0, 12'd490, 12'd3590);
		// one full calibration set sweeping both axes; the last word completes
		// it and is mapped with the new centres (x 1900ish, y 2195ish)
		for (k = 0; k < CAL_SAMPLES; k++) begin
			xs = (k == CAL_SAMPLES - 1) ? 12'd4095 : SAMPLE_W'(k * 200);
			ys = SAMPLE_W'(SAMPLE_MAX - k * 200);
			send(1'b1, xs, ys);
		end

		// --- random phases, each with its own limit setting ---
		for (p = 0; p < N_PHASES; p++) begin
			xt = pick_target();
			yt = pick_target();
			gap_on = ($urandom_range(0, 3) != 0);
			drain();
			case (p)
				0: set_limits(0, SAMPLE_MAX, 0, SAMPLE_MAX);
				1: set_limits(SAMPLE_MAX, 0, SAMPLE_MAX, 0);  // inverted, both axes
				2: set_limits($urandom_range(0, 2047), $urandom_range(2048, SAMPLE_MAX),
					$urandom_range(0, 2047), $urandom_range(2048, SAMPLE_MAX));
				3: begin
					// zero span: finish the open set and run a constant one so
					// the centres land exactly on the targets, then put the x limits and the y low limit there
					n = (CAL_SAMPLES - cal_sent % CAL_SAMPLES) % CAL_SAMPLES + CAL_SAMPLES;
					for (k = 0; k < n; k++)
						send(1'b1, SAMPLE_W'(xt), SAMPLE_W'(yt));
					drain();
					set_limits(xt, xt, yt, $urandom_range(0, SAMPLE_MAX));
					// map words right at, just below and just above the centre
					send(1'b0, SAMPLE_W'(xt), SAMPLE_W'(yt));
					send(1'b0, SAMPLE_W'(clamp_sample(xt - 1)), SAMPLE_W'(clamp_sample(yt - 1)));
					send(1'b0, SAMPLE_W'(clamp_sample(xt + 1)), SAMPLE_W'(clamp_sample(yt + 1)));
				end
				4: set_limits($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
					$urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX));
				5: set_limits(int'(X_LOW_RST), int'(X_HIGH_RST), int'(Y_LOW_RST),
					int'(Y_HIGH_RST));
				default: begin
					// narrow window around where the centres are heading
					xl = clamp_sample(xt - $urandom_range(1, 60));
					xh = clamp_sample(xt + $urandom_range(1, 60));
					yl = clamp_sample(yt - $urandom_range(1, 60));
					yh = clamp_sample(yt + $urandom_range(1, 60));
					set_limits(xl, xh, yl, yh);
				end
			endcase

			for (k = 0; k < PHASE_WORDS; k++) begin
				if (k % 25 == 24)
					gap_on = ($urandom_range(0, 3) != 0);
				op = 1'($urandom_range(0, 1));
				if (op && $urandom_range(0, 9) != 0) begin
					// calibration words cluster around the target, with jitter
					xs = SAMPLE_W'(clamp_sample(xt + $urandom_range(0, 16) - 8));
					ys = SAMPLE_W'(clamp_sample(yt + $urandom_range(0, 16) - 8));
				end else begin
					xs = pick_sample(xt, lim[REG_X_LOW], lim[REG_X_HIGH]);
					ys = pick_sample(yt, lim[REG_Y_LOW], lim[REG_Y_HIGH]);
				end
				send(op, xs, ys);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d result words, %0d completed calibration sets, %0d limit settings",
			words_checked, sets_done, n_settings);
		$display("Limits covered: reset, rails, inverted, zero span, random and narrow windows");
		if (errors == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d failures, %0d words still outstanding", errors, pending);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
